@@ rtl/bgd_pkg.sv @@
// Package for the button gesture decoder: widths, button and event codes,
// register indexes, reset values and the event record type. No dependencies.
`default_nettype none

package bgd_pkg;

  localparam int TIME_BITS = 48;
  localparam int CFG_BITS  = 24;
  localparam int NUM_BTN   = 3;

  // Candidate event slots: two chord-layer releases, chord, two chord-window
  // timeouts, mode press, then five slots per button.
  localparam int NUM_CAND  = 6 + 5 * NUM_BTN;
  localparam int SEL_BITS  = $clog2(NUM_CAND);

  localparam logic [1:0] B_UP   = 2'd0;
  localparam logic [1:0] B_MODE = 2'd1;
  localparam logic [1:0] B_DOWN = 2'd2;

  localparam logic [2:0] EV_DOWN      = 3'd0;
  localparam logic [2:0] EV_UP        = 3'd1;
  localparam logic [2:0] EV_SHORT     = 3'd2;
  localparam logic [2:0] EV_HOLD      = 3'd3;
  localparam logic [2:0] EV_HOLD_END  = 3'd4;
  localparam logic [2:0] EV_REPEAT    = 3'd5;
  localparam logic [2:0] EV_CHORD     = 3'd6;
  localparam logic [2:0] EV_CHORD_END = 3'd7;

  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_CHORD_WIN   = 3'd1;
  localparam logic [2:0] REG_CHORD_HOLD  = 3'd2;
  localparam logic [2:0] REG_HOLD        = 3'd3;
  localparam logic [2:0] REG_REPEAT      = 3'd4;
  localparam logic [2:0] REG_START_LATCH = 3'd5;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = CFG_BITS'(20 * 1000);
  localparam logic [CFG_BITS-1:0] CHORD_WIN_RST  = CFG_BITS'(80 * 1000);
  localparam logic [CFG_BITS-1:0] CHORD_HOLD_RST = CFG_BITS'(200 * 1000);
  localparam logic [CFG_BITS-1:0] HOLD_RST       = CFG_BITS'(600 * 1000);
  localparam logic [CFG_BITS-1:0] REPEAT_RST     = CFG_BITS'(150 * 1000);

  typedef struct packed {
    logic [1:0]           id;
    logic [2:0]           kind;
    logic [TIME_BITS-1:0] stamp;
  } ev_t;

  // Elapsed time, modulo the timestamp width.
  function automatic logic [TIME_BITS-1:0] since(input logic [TIME_BITS-1:0] now,
                                                 input logic [TIME_BITS-1:0] then_t);
    return now - then_t;
  endfunction

  function automatic logic [TIME_BITS-1:0] ext(input logic [CFG_BITS-1:0] v);
    return {{(TIME_BITS - CFG_BITS){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

@@ rtl/button_gesture_decoder.sv @@
// Button gesture decoder: debounce, chord, hold and repeat detection for
// three buttons. Depends on bgd_pkg.
// Latency: a sample's first event is presented in the cycle after the sample is taken.
// Throughput: the event bank holds a sample's events until each has left; the
// next sample is taken once the bank is empty or in the cycle its last event
// leaves, so single-event samples stream one per cycle while out_stall is low.
// Reset clears all button state and restores the default register values.
`default_nettype none

module button_gesture_decoder import bgd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 raw_up,
  input  wire logic                 raw_mode,
  input  wire logic                 raw_down,
  input  wire logic [TIME_BITS-1:0] sample_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                button_id,
  output logic [2:0]                event_kind,
  output logic [TIME_BITS-1:0]      event_time,
  output logic                      last_event
);

  logic [CFG_BITS-1:0] debounce_time, chord_window, chord_hold_time, hold_time;
  logic [CFG_BITS-1:0] repeat_interval;

  logic [NUM_BTN-1:0]   raw_level, stable_level, pending_flag, chord_member;
  logic [NUM_BTN-1:0]   reported_flag, held_flag;
  logic [TIME_BITS-1:0] edge_time [NUM_BTN];
  logic [TIME_BITS-1:0] press_time [NUM_BTN];
  logic [TIME_BITS-1:0] repeat_time [NUM_BTN];
  logic [TIME_BITS-1:0] chord_start;
  logic                 chord_valid, chord_on, wake_lock;

  logic [NUM_BTN-1:0]   raw_level_next, stable_level_next, pending_flag_next;
  logic [NUM_BTN-1:0]   chord_member_next, reported_flag_next, held_flag_next;
  logic [TIME_BITS-1:0] edge_time_next [NUM_BTN];
  logic [TIME_BITS-1:0] press_time_next [NUM_BTN];
  logic [TIME_BITS-1:0] repeat_time_next [NUM_BTN];
  logic [TIME_BITS-1:0] chord_start_next;
  logic                 chord_valid_next, chord_on_next, wake_lock_next;

  logic [NUM_CAND-1:0]  cand_mask;
  ev_t                  cand [NUM_CAND];

  // Event bank: one slot per candidate, drained lowest slot first.
  logic [NUM_CAND-1:0]  ev_mask;
  ev_t                  ev_bank [NUM_CAND];
  logic [SEL_BITS-1:0]  sel;
  logic [NUM_CAND-1:0]  sel_bit;

  logic [NUM_BTN-1:0]   raw_in;
  logic                 in_acc, out_acc;

  assign raw_in  = {raw_down, raw_mode, raw_up};
  assign out_acc = out_valid && !out_stall;
  assign in_stall = !((ev_mask == '0) || (out_acc && last_event));
  assign in_acc  = in_valid && !in_stall;

  always_comb begin
    logic [NUM_BTN-1:0]   changed;
    logic [1:0]           bi, bo;
    logic                 partner, skip;
    int                   base;
    raw_level_next     = raw_level;
    stable_level_next  = stable_level;
    pending_flag_next  = pending_flag;
    chord_member_next  = chord_member;
    reported_flag_next = reported_flag;
    held_flag_next     = held_flag;
    edge_time_next     = edge_time;
    press_time_next    = press_time;
    repeat_time_next   = repeat_time;
    chord_start_next   = chord_start;
    chord_valid_next   = chord_valid;
    chord_on_next      = chord_on;
    wake_lock_next     = wake_lock;
    cand_mask          = '0;
    changed            = '0;
    bi                 = B_UP;
    bo                 = B_DOWN;
    partner            = 1'b0;
    skip               = 1'b0;
    base               = 0;
    for (int k = 0; k < NUM_CAND; k++) begin
      cand[k] = '{id: B_UP, kind: EV_DOWN, stamp: sample_time};
    end

    for (int i = 0; i < NUM_BTN; i++) begin
      if (raw_in[i] != raw_level_next[i]) begin
        raw_level_next[i] = raw_in[i];
        edge_time_next[i] = sample_time;
      end
      if (raw_in[i] != stable_level_next[i] &&
          since(sample_time, edge_time_next[i]) >= ext(debounce_time)) begin
        stable_level_next[i] = raw_in[i];
        changed[i] = 1'b1;
      end
    end

    if (wake_lock) begin
      if (stable_level_next == '0) begin
        wake_lock_next = 1'b0;
      end
    end else begin
      // Chord layer, up then down.
      for (int j = 0; j < 2; j++) begin
        bi = 2'(j * 2);
        bo = 2'(2 - j * 2);
        if (changed[bi] && stable_level_next[bi]) begin
          press_time_next[bi] = sample_time;
          if (pending_flag_next[bo] || chord_member_next[bo]) begin
            chord_member_next[bi] = 1'b1;
            chord_member_next[bo] = 1'b1;
            pending_flag_next[bo] = 1'b0;
            pending_flag_next[bi] = 1'b0;
            if (!chord_valid_next) begin
              chord_start_next = sample_time;
              chord_valid_next = 1'b1;
            end
          end else if (stable_level_next[bo] && reported_flag_next[bo]) begin
            chord_member_next[bi] = 1'b1;
            chord_member_next[bo] = 1'b1;
            cand_mask[j] = 1'b1;
            cand[j] = '{id: bo, kind: EV_UP, stamp: sample_time};
            reported_flag_next[bo] = 1'b0;
            held_flag_next[bo] = 1'b0;
            chord_start_next = sample_time;
            chord_valid_next = 1'b1;
          end else begin
            pending_flag_next[bi] = 1'b1;
          end
        end
      end

      if (!chord_on_next && chord_valid_next && chord_member_next[B_UP] &&
          chord_member_next[B_DOWN] &&
          since(sample_time, chord_start_next) >= ext(chord_hold_time)) begin
        chord_on_next = 1'b1;
        cand_mask[2] = 1'b1;
        cand[2] = '{id: B_UP, kind: EV_CHORD, stamp: sample_time};
      end

      for (int j = 0; j < 2; j++) begin
        bi = 2'(j * 2);
        if (pending_flag_next[bi] &&
            since(sample_time, press_time_next[bi]) >= ext(chord_window)) begin
          pending_flag_next[bi] = 1'b0;
          reported_flag_next[bi] = 1'b1;
          cand_mask[3 + j] = 1'b1;
          cand[3 + j] = '{id: bi, kind: EV_DOWN, stamp: press_time_next[bi]};
        end
      end

      if (changed[B_MODE] && stable_level_next[B_MODE]) begin
        press_time_next[B_MODE] = sample_time;
        reported_flag_next[B_MODE] = 1'b1;
        cand_mask[5] = 1'b1;
        cand[5] = '{id: B_MODE, kind: EV_DOWN, stamp: sample_time};
      end

      for (int i = 0; i < NUM_BTN; i++) begin
        bi = 2'(i);
        base = 6 + 5 * i;
        skip = 1'b0;
        if (changed[i] && !stable_level_next[i]) begin
          if (chord_member_next[i]) begin
            chord_member_next[i] = 1'b0;
            if (bi == B_UP) begin
              partner = chord_member_next[B_DOWN];
            end else if (bi == B_DOWN) begin
              partner = chord_member_next[B_UP];
            end else begin
              partner = 1'b0;
            end
            if (!partner) begin
              chord_start_next = '0;
              chord_valid_next = 1'b0;
            end
            if (chord_on_next && !partner) begin
              chord_on_next = 1'b0;
              cand_mask[base] = 1'b1;
              cand[base] = '{id: B_UP, kind: EV_CHORD_END, stamp: sample_time};
            end
            skip = 1'b1;
          end else if (pending_flag_next[i]) begin
            pending_flag_next[i] = 1'b0;
            cand_mask[base]     = 1'b1;
            cand[base]          = '{id: bi, kind: EV_DOWN, stamp: press_time_next[i]};
            cand_mask[base + 1] = 1'b1;
            cand[base + 1]      = '{id: bi, kind: EV_UP, stamp: sample_time};
            cand_mask[base + 2] = 1'b1;
            cand[base + 2]      = '{id: bi, kind: EV_SHORT, stamp: sample_time};
            skip = 1'b1;
          end else if (reported_flag_next[i]) begin
            cand_mask[base]     = 1'b1;
            cand[base]          = '{id: bi, kind: EV_UP, stamp: sample_time};
            cand_mask[base + 1] = 1'b1;
            cand[base + 1]      = '{id: bi,
                                    kind: held_flag_next[i] ? EV_HOLD_END : EV_SHORT,
                                    stamp: sample_time};
            reported_flag_next[i] = 1'b0;
            held_flag_next[i] = 1'b0;
          end
        end
        if (!skip && reported_flag_next[i] && stable_level_next[i] &&
            !chord_member_next[i]) begin
          if (!held_flag_next[i] &&
              since(sample_time, press_time_next[i]) >= ext(hold_time)) begin
            held_flag_next[i] = 1'b1;
            repeat_time_next[i] = sample_time;
            cand_mask[base + 3] = 1'b1;
            cand[base + 3] = '{id: bi, kind: EV_HOLD, stamp: sample_time};
          end
          if (held_flag_next[i] &&
              since(sample_time, repeat_time_next[i]) >= ext(repeat_interval)) begin
            repeat_time_next[i] = sample_time;
            cand_mask[base + 4] = 1'b1;
            cand[base + 4] = '{id: bi, kind: EV_REPEAT, stamp: sample_time};
          end
        end
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int k = NUM_CAND - 1; k >= 0; k--) begin
      if (ev_mask[k]) begin
        sel = SEL_BITS'(k);
      end
    end
    sel_bit = '0;
    sel_bit[sel] = 1'b1;
  end

  assign out_valid  = (ev_mask != '0);
  assign button_id  = ev_bank[sel].id;
  assign event_kind = ev_bank[sel].kind;
  assign event_time = ev_bank[sel].stamp;
  assign last_event = ((ev_mask & ~sel_bit) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RST;
      chord_window    <= CHORD_WIN_RST;
      chord_hold_time <= CHORD_HOLD_RST;
      hold_time       <= HOLD_RST;
      repeat_interval <= REPEAT_RST;
      raw_level       <= '0;
      stable_level    <= '0;
      pending_flag    <= '0;
      chord_member    <= '0;
      reported_flag   <= '0;
      held_flag       <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        edge_time[i]   <= '0;
        press_time[i]  <= '0;
        repeat_time[i] <= '0;
      end
      chord_start <= '0;
      chord_valid <= 1'b0;
      chord_on    <= 1'b0;
      wake_lock   <= 1'b0;
      ev_mask     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE:    debounce_time   <= cfg_data;
          REG_CHORD_WIN:   chord_window    <= cfg_data;
          REG_CHORD_HOLD:  chord_hold_time <= cfg_data;
          REG_HOLD:        hold_time       <= cfg_data;
          REG_REPEAT:      repeat_interval <= cfg_data;
          REG_START_LATCH: wake_lock       <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        raw_level     <= raw_level_next;
        stable_level  <= stable_level_next;
        pending_flag  <= pending_flag_next;
        chord_member  <= chord_member_next;
        reported_flag <= reported_flag_next;
        held_flag     <= held_flag_next;
        edge_time     <= edge_time_next;
        press_time    <= press_time_next;
        repeat_time   <= repeat_time_next;
        chord_start   <= chord_start_next;
        chord_valid   <= chord_valid_next;
        chord_on      <= chord_on_next;
        wake_lock     <= wake_lock_next;
        ev_mask       <= cand_mask;
      end else if (out_acc) begin
        ev_mask <= ev_mask & ~sel_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_bank <= cand;
    end
  end

  // A new sample is only taken when the bank is empty or its last event leaves.
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (ev_mask == '0 || (out_acc && last_event)))
    else $error("sample accepted while events were still pending");

  // While the wake latch is set a sample produces no events.
  a_wake_silent: assert property (@(posedge clk) disable iff (rst)
    (in_acc && wake_lock) |=> !out_valid)
    else $error("events produced while wake latch set");

  // The last event flag marks exactly one remaining slot.
  a_last_onehot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_event) |-> $onehot(ev_mask))
    else $error("last event flagged with more events pending");

  // A drained event leaves the bank with one fewer entry.
  a_drain_one: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !in_acc) |=> ($countones(ev_mask) == $countones($past(ev_mask)) - 1))
    else $error("event bank did not drain by one");

endmodule

`default_nettype wire

@@ tb/button_gesture_decoder_test.sv @@
// Self-checking testbench for button_gesture_decoder: timestamped button samples
// go in, a local gesture predictor produces the expected events. Depends on bgd_pkg.
`default_nettype none

module button_gesture_decoder_test;
  import bgd_pkg::*;

  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic                 up;
    logic                 mode;
    logic                 down;
    logic [TIME_BITS-1:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [1:0]           id;
    logic [2:0]           kind;
    logic [TIME_BITS-1:0] stamp;
    logic                 last;
  } gesture_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic raw_up = 1'b0, raw_mode = 1'b0, raw_down = 1'b0;
  logic [TIME_BITS-1:0] sample_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] button_id;
  logic [2:0] event_kind;
  logic [TIME_BITS-1:0] event_time;
  logic last_event;

  button_gesture_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .raw_up(raw_up), .raw_mode(raw_mode),
    .raw_down(raw_down), .sample_time(sample_time), .out_valid(out_valid),
    .out_stall(out_stall), .button_id(button_id), .event_kind(event_kind),
    .event_time(event_time), .last_event(last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of configuration and per-button state.
  logic [CFG_BITS-1:0] p_debounce, p_chord_win, p_chord_hold, p_hold, p_repeat;
  logic [2:0] p_raw, p_stable, p_pending, p_member, p_reported, p_held;
  logic [TIME_BITS-1:0] p_edge [3];
  logic [TIME_BITS-1:0] p_press [3];
  logic [TIME_BITS-1:0] p_rep [3];
  logic [TIME_BITS-1:0] p_chord_start;
  logic p_chord_valid, p_chord_on, p_wake;

  sample_t pending_samples[$];
  gesture_t expected_gestures[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_off = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit pause_send = 1'b0;
  int n_added;

  function automatic logic [TIME_BITS-1:0] elapsed(logic [TIME_BITS-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
    return a - b;
  endfunction

  task automatic reset_predictor();
    p_debounce = DEBOUNCE_RST; p_chord_win = CHORD_WIN_RST; p_chord_hold = CHORD_HOLD_RST;
    p_hold = HOLD_RST; p_repeat = REPEAT_RST;
    p_raw = '0; p_stable = '0; p_pending = '0; p_member = '0; p_reported = '0; p_held = '0;
    for (int i = 0; i < 3; i++) begin
      p_edge[i] = '0; p_press[i] = '0; p_rep[i] = '0;
    end
    p_chord_start = '0; p_chord_valid = 1'b0; p_chord_on = 1'b0; p_wake = 1'b0;
  endtask

  task automatic add_gesture(int id, logic [2:0] kind, logic [TIME_BITS-1:0] t);
    gesture_t g;
    if (n_added >= 12) return;
    g.id = 2'(id); g.kind = kind; g.stamp = t; g.last = 1'b0;
    expected_gestures.push_back(g);
    n_added++;
  endtask

  task automatic predict_gestures(sample_t s);
    logic [TIME_BITS-1:0] now;
    logic [2:0] r, changed;
    int o;
    bit partner;
    now = s.stamp;
    r = {s.down, s.mode, s.up};
    changed = '0;
    n_added = 0;
    for (int i = 0; i < 3; i++) begin
      if (r[i] != p_raw[i]) begin
        p_raw[i] = r[i];
        p_edge[i] = now;
      end
      if (r[i] != p_stable[i] && elapsed(now, p_edge[i]) >= ext(p_debounce)) begin
        p_stable[i] = r[i];
        changed[i] = 1'b1;
      end
    end
    if (p_wake) begin
      if (p_stable == 3'b000) p_wake = 1'b0;
      return;
    end
    for (int i = 0; i < 3; i += 2) begin
      o = 2 - i;
      if (changed[i] && p_stable[i]) begin
        p_press[i] = now;
        if (p_pending[o] || p_member[o]) begin
          p_member[i] = 1'b1; p_member[o] = 1'b1;
          p_pending[o] = 1'b0; p_pending[i] = 1'b0;
          if (!p_chord_valid) begin
            p_chord_start = now;
            p_chord_valid = 1'b1;
          end
        end else if (p_stable[o] && p_reported[o]) begin
          p_member[i] = 1'b1; p_member[o] = 1'b1;
          add_gesture(o, EV_UP, now);
          p_reported[o] = 1'b0; p_held[o] = 1'b0;
          p_chord_start = now; p_chord_valid = 1'b1;
        end else begin
          p_pending[i] = 1'b1;
        end
      end
    end
    if (!p_chord_on && p_chord_valid && p_member[B_UP] && p_member[B_DOWN] &&
        elapsed(now, p_chord_start) >= ext(p_chord_hold)) begin
      p_chord_on = 1'b1;
      add_gesture(B_UP, EV_CHORD, now);
    end
    for (int i = 0; i < 3; i += 2) begin
      if (p_pending[i] && elapsed(now, p_press[i]) >= ext(p_chord_win)) begin
        p_pending[i] = 1'b0; p_reported[i] = 1'b1;
        add_gesture(i, EV_DOWN, p_press[i]);
      end
    end
    if (changed[B_MODE] && p_stable[B_MODE]) begin
      p_press[B_MODE] = now; p_reported[B_MODE] = 1'b1;
      add_gesture(B_MODE, EV_DOWN, now);
    end
    for (int i = 0; i < 3; i++) begin
      if (changed[i] && !p_stable[i]) begin
        if (p_member[i]) begin
          p_member[i] = 1'b0;
          partner = (i == B_UP) ? p_member[B_DOWN] : (i == B_DOWN) ? p_member[B_UP] : 1'b0;
          if (!partner) begin
            p_chord_start = '0; p_chord_valid = 1'b0;
          end
          if (p_chord_on && !partner) begin
            p_chord_on = 1'b0;
            add_gesture(B_UP, EV_CHORD_END, now);
          end
          continue;
        end
        if (p_pending[i]) begin
          p_pending[i] = 1'b0;
          add_gesture(i, EV_DOWN, p_press[i]);
          add_gesture(i, EV_UP, now);
          add_gesture(i, EV_SHORT, now);
          continue;
        end
        if (p_reported[i]) begin
          add_gesture(i, EV_UP, now);
          add_gesture(i, p_held[i] ? EV_HOLD_END : EV_SHORT, now);
          p_reported[i] = 1'b0; p_held[i] = 1'b0;
        end
      end
      if (p_reported[i] && p_stable[i] && !p_member[i]) begin
        if (!p_held[i] && elapsed(now, p_press[i]) >= ext(p_hold)) begin
          p_held[i] = 1'b1; p_rep[i] = now;
          add_gesture(i, EV_HOLD, now);
        end
        if (p_held[i] && elapsed(now, p_rep[i]) >= ext(p_repeat)) begin
          p_rep[i] = now;
          add_gesture(i, EV_REPEAT, now);
        end
      end
    end
    if (n_added > 0) expected_gestures[$].last = 1'b1;
  endtask

  // Sender: draws from the sample queue, predicts on acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict_gestures({raw_up, raw_mode, raw_down, sample_time});
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && !pause_send &&
            (quiet || $urandom_range(99) >= 24)) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_valid <= 1'b1;
          raw_up <= s.up; raw_mode <= s.mode; raw_down <= s.down; sample_time <= s.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, a counted long hold-off on request.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_gestures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event id=%0d kind=%0d time=%0d",
                                       button_id, event_kind, event_time);
      end else begin
        gesture_t g;
        g = expected_gestures.pop_front();
        if (g != {button_id, event_kind, event_time, last_event}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id=%0d kind=%0d time=%0d last=%0b, got %0d %0d %0d %0b",
                     g.id, g.kind, g.stamp, g.last, button_id, event_kind, event_time,
                     last_event);
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 400;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:   p_debounce = val;
      REG_CHORD_WIN:  p_chord_win = val;
      REG_CHORD_HOLD: p_chord_hold = val;
      REG_HOLD:       p_hold = val;
      REG_REPEAT:     p_repeat = val;
      REG_START_LATCH: p_wake = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_gestures.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  logic [TIME_BITS-1:0] clock_us = '0;

  task automatic queue_sample(logic [2:0] btn, int unsigned step);
    sample_t s;
    clock_us = clock_us + step;
    s.up = btn[0]; s.mode = btn[1]; s.down = btn[2]; s.stamp = clock_us;
    pending_samples.push_back(s);
  endtask

  // Gesture scripts: a button pattern held over one to six polls, then released.
  task automatic queue_gestures(int n, int unsigned max_step);
    logic [2:0] btn;
    int polls;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) btn = 3'($urandom);
      else btn = ($urandom_range(3) == 0) ? 3'b101 : 3'(1 << $urandom_range(2));
      polls = $urandom_range(1, 6);
      for (int p = 0; p < polls; p++) begin
        // Occasional bounce on one button.
        queue_sample(($urandom_range(7) == 0) ? btn ^ 3'(1 << $urandom_range(2)) : btn,
                     $urandom_range(1, max_step));
      end
      queue_sample(3'b000, $urandom_range(1, max_step));
    end
  endtask

  initial begin
    reset_predictor();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: defaults, short press, hold with repeats, chord, mode.
    queue_sample(3'b001, 1000);  queue_sample(3'b001, 30000);
    queue_sample(3'b000, 100000); queue_sample(3'b000, 30000);
    queue_sample(3'b010, 1000);  queue_sample(3'b010, 25000);
    queue_sample(3'b010, 700000); queue_sample(3'b010, 200000);
    queue_sample(3'b000, 1000);  queue_sample(3'b000, 30000);
    queue_sample(3'b101, 1000);  queue_sample(3'b101, 25000);
    queue_sample(3'b101, 300000); queue_sample(3'b000, 1000);
    queue_sample(3'b000, 30000);
    queue_sample(3'b100, 1000);  queue_sample(3'b100, 25000);
    queue_sample(3'b100, 100000); queue_sample(3'b101, 1000);
    queue_sample(3'b101, 25000); queue_sample(3'b111, 300000);
    queue_sample(3'b000, 1000);  queue_sample(3'b000, 30000);
    drain();

    // Zero timings, stamps up to all-ones and a wrap to zero.
    write_reg(REG_DEBOUNCE, '0); write_reg(REG_CHORD_WIN, '0);
    write_reg(REG_CHORD_HOLD, '0); write_reg(REG_HOLD, '0); write_reg(REG_REPEAT, '0);
    clock_us = '1 - 3;
    queue_sample(3'b111, 1); queue_sample(3'b111, 1); queue_sample(3'b000, 1);
    queue_sample(3'b101, 1); queue_sample(3'b000, 1);
    drain();

    // Maximum timings, then the wake latch.
    write_reg(REG_DEBOUNCE, '1); write_reg(REG_CHORD_WIN, '1);
    write_reg(REG_CHORD_HOLD, '1); write_reg(REG_HOLD, '1); write_reg(REG_REPEAT, '1);
    write_reg(REG_START_LATCH, 1'b1);
    queue_gestures(10, 9000000);
    drain();

    // Small timings with random gestures; a long receiver hold-off fills the block.
    write_reg(REG_START_LATCH, 1'b0);
    write_reg(REG_DEBOUNCE, 24'd20); write_reg(REG_CHORD_WIN, 24'd50);
    write_reg(REG_CHORD_HOLD, 24'd80); write_reg(REG_HOLD, 24'd120);
    write_reg(REG_REPEAT, 24'd40);
    hold_req = 1'b1;
    queue_gestures(30, 60);
    drain();

    quiet = 1'b1;
    queue_gestures(15, 60);
    drain();
    quiet = 1'b0;

    // Sender pause until all results are in, then random timings from a random start time.
    queue_gestures(5, 60);
    repeat (15) @(posedge clk);
    pause_send = 1'b1;
    while (in_valid || expected_gestures.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    pause_send = 1'b0;
    drain();

    write_reg(REG_DEBOUNCE, 24'($urandom_range(10, 40)));
    write_reg(REG_CHORD_WIN, 24'($urandom_range(20, 100)));
    write_reg(REG_CHORD_HOLD, 24'($urandom_range(20, 200)));
    write_reg(REG_HOLD, 24'($urandom_range(50, 250)));
    write_reg(REG_REPEAT, 24'($urandom_range(1, 80)));
    clock_us = {$urandom, $urandom};
    queue_gestures(25, 80);
    drain();

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
